// ----- rtl/stepped_light_pattern_player_assert.svh -----
// Assertion macros used by the player controller.
`ifndef STEPPED_LIGHT_PATTERN_PLAYER_ASSERT_SVH
`define STEPPED_LIGHT_PATTERN_PLAYER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SLPP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define SLPP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SLPP_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define SLPP_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- rtl/slpp_pkg.sv -----
// Shared types and constants of the stepped light pattern player.
`timescale 1ns / 1ps
package slpp_pkg;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic REG_BASE_LEVEL   = 1'b0;
  localparam logic REG_ACTIVE_STEPS = 1'b1;

  localparam int LEVEL_W = 8;
  localparam int LENGTH_W = 16;
  localparam int TIME_W = 32;
  localparam int ACTIVE_W = 5;
  localparam int DIV_CW = 5;
  localparam logic [DIV_CW-1:0] DIV_LAST = 5'd31;

  typedef struct packed {
    logic load;
    logic latch;
    logic rd;
    logic div_init;
    logic div_step;
    logic out_hit;
    logic out_base;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic idx_end;
    logic pend;
    logic total_zero;
    logic div_done;
    logic hit;
  } sts_t;

endpackage

// ----- rtl/slpp_datapath.sv -----
// Datapath: step memory, config registers, accumulator, divider, output register.
`timescale 1ns / 1ps
module slpp_datapath #(
  parameter int MAX_STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  input  slpp_pkg::cmd_t cmd,
  output slpp_pkg::sts_t sts,
  input  logic [3:0] step_index,
  input  logic [7:0] step_level,
  input  logic [15:0] step_length,
  input  logic [31:0] elapsed_time,
  input  logic [31:0] phase_offset,
  input  logic wr_en,
  input  logic wr_index,
  input  logic [7:0] wr_data,
  output logic [7:0] level_out,
  output logic done
);
  import slpp_pkg::*;

  localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int CW = $clog2(MAX_STEPS + 1);
  localparam int TW = LENGTH_W + $clog2(MAX_STEPS + 1);
  localparam int EW = LEVEL_W + LENGTH_W;

  logic [EW-1:0] mem [MAX_STEPS];
  logic [EW-1:0] rd_data;

  logic [LEVEL_W-1:0] base_level;
  logic [ACTIVE_W-1:0] active_steps;

  logic [CW-1:0] used;
  logic [CW-1:0] n;
  logic [CW-1:0] idx;
  logic pend;
  logic [TW-1:0] acc;
  logic [TW-1:0] total;
  logic [TW-1:0] rem;
  logic [TIME_W-1:0] dvd;
  logic [DIV_CW-1:0] dcnt;
  logic [TW:0] shifted;
  logic [TW-1:0] acc_plus;
  logic [LENGTH_W-1:0] rd_len;
  logic [LEVEL_W-1:0] rd_level;
  logic slot_ok;

  assign rd_len = rd_data[LENGTH_W-1:0];
  assign rd_level = rd_data[EW-1:LENGTH_W];
  assign acc_plus = acc + TW'(rd_len);
  assign shifted = {rem, dvd[TIME_W-1]};
  assign slot_ok = 32'(step_index) < MAX_STEPS;
  assign used = (32'(active_steps) > MAX_STEPS) ? CW'(MAX_STEPS) : CW'(active_steps);

  always_comb begin
    sts.n_zero = active_steps == '0;
    sts.idx_end = idx == n;
    sts.pend = pend;
    sts.total_zero = acc == '0;
    sts.div_done = dcnt == DIV_LAST;
    sts.hit = pend && (rem < acc_plus);
  end

  always_ff @(posedge clk) begin
    if (cmd.load && slot_ok) begin
      mem[AW'(step_index)] <= {step_level, step_length};
    end
    if (cmd.rd) begin
      rd_data <= mem[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_level <= '0;
      active_steps <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_BASE_LEVEL: base_level <= wr_data;
        REG_ACTIVE_STEPS: active_steps <= wr_data[ACTIVE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      done <= 1'b0;
    end else begin
      pend <= cmd.rd;
      done <= cmd.out_hit | cmd.out_base;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      dvd <= elapsed_time + phase_offset;
      n <= used;
      idx <= '0;
      acc <= '0;
    end else if (cmd.div_init) begin
      total <= acc;
      acc <= '0;
      idx <= '0;
      rem <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      if (shifted >= {1'b0, total}) begin
        rem <= TW'(shifted - {1'b0, total});
      end else begin
        rem <= shifted[TW-1:0];
      end
      dvd <= dvd << 1;
      dcnt <= dcnt + 1'b1;
    end else begin
      if (cmd.rd) begin
        idx <= idx + 1'b1;
      end
      if (pend) begin
        acc <= acc_plus;
      end
    end
    if (cmd.out_hit) begin
      level_out <= rd_level;
    end else if (cmd.out_base) begin
      level_out <= base_level;
    end
  end

endmodule

// ----- rtl/slpp_ctrl.sv -----
// Controller: sequences the sum walk, the division and the scan walk.
`timescale 1ns / 1ps
`include "stepped_light_pattern_player_assert.svh"
module slpp_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic kind,
  input  slpp_pkg::sts_t sts,
  output slpp_pkg::cmd_t cmd,
  output logic busy
);
  import slpp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_SCAN = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign busy = state != ST_IDLE;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start && kind == KIND_LOAD) begin
          cmd.load = 1'b1;
        end else if (start && kind == KIND_QUERY) begin
          if (sts.n_zero) begin
            cmd.out_base = 1'b1;
          end else begin
            cmd.latch = 1'b1;
            state_next = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        cmd.rd = !sts.idx_end;
        if (sts.idx_end && !sts.pend) begin
          if (sts.total_zero) begin
            cmd.out_base = 1'b1;
            state_next = ST_IDLE;
          end else begin
            cmd.div_init = 1'b1;
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd = !sts.idx_end && !sts.hit;
        if (sts.hit) begin
          cmd.out_hit = 1'b1;
          state_next = ST_IDLE;
        end else if (sts.idx_end && !sts.pend) begin
          cmd.out_base = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `SLPP_ASSERT_IMP(a_one_result, clk, rst, 1'b1, !(cmd.out_hit && cmd.out_base), "two results in one cycle")
  `SLPP_ASSERT_NXT(a_hit_ends, clk, rst, state == ST_SCAN && sts.hit, state == ST_IDLE, "scan did not end on hit")
  `SLPP_ASSERT_NXT(a_query_walks, clk, rst, state == ST_IDLE && start && kind == KIND_QUERY && !sts.n_zero, state == ST_SUM, "query did not start sum walk")
  `SLPP_ASSERT_NXT(a_div_full, clk, rst, state == ST_DIV && !sts.div_done, state == ST_DIV, "division left early")

endmodule

// ----- rtl/stepped_light_pattern_player.sv -----
// Load beat: table write at the accepting edge, no result, busy stays low.
// Query beat with no active steps: done in the cycle after acceptance, busy stays low.
// Otherwise, over n used steps, a sum walk adds the step lengths; a zero sum gives base_level,
// else a restoring divider, a scan walk and the output register follow before done.
// One query at a time; busy is high from the cycle after acceptance until the cycle before done.
// Synchronous reset clears config registers and control; step table is undefined until loaded.
`timescale 1ns / 1ps
module stepped_light_pattern_player #(
  parameter int MAX_STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic kind,
  input  logic [3:0] step_index,
  input  logic [7:0] step_level,
  input  logic [15:0] step_length,
  input  logic [31:0] elapsed_time,
  input  logic [31:0] phase_offset,
  input  logic wr_en,
  input  logic wr_index,
  input  logic [7:0] wr_data,
  output logic [7:0] level_out,
  output logic done
);
  import slpp_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic start_ok;

  assign start_ok = start && !busy;

  slpp_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .start(start_ok),
    .kind(kind),
    .sts(sts),
    .cmd(cmd),
    .busy(busy)
  );

  slpp_datapath #(
    .MAX_STEPS(MAX_STEPS)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .sts(sts),
    .step_index(step_index),
    .step_level(step_level),
    .step_length(step_length),
    .elapsed_time(elapsed_time),
    .phase_offset(phase_offset),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .level_out(level_out),
    .done(done)
  );

endmodule
